>>> rtl/ase_pkg.sv
// shared command codes and constants for the active error set
package ase_pkg;

  // command codes carried on the input channel
  localparam logic [1:0] CMD_ADD       = 2'd0;
  localparam logic [1:0] CMD_REMOVE    = 2'd1;
  localparam logic [1:0] CMD_VIEW_FIRST = 2'd2;
  localparam logic [1:0] CMD_VIEW_NEXT = 2'd3;

  // width of the shown code on the result channel
  localparam int unsigned SHOWN_BITS = 8;

endpackage

>>> rtl/ase_slot_store.sv
// slot memory with per-slot occupied flags and a registered read port
module ase_slot_store #(
  parameter int SLOT_COUNT = 16,
  parameter int CODE_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  output logic [CODE_BITS-1:0]          rd_data,
  output logic                          rd_occ,
  input  logic                          wr_en,
  input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  input  logic [CODE_BITS-1:0]          wr_data,
  input  logic                          clr_en,
  input  logic [$clog2(SLOT_COUNT)-1:0] clr_addr
);

  logic [CODE_BITS-1:0]  mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] occ_r;
  logic [CODE_BITS-1:0]  rd_data_r;
  logic                  rd_occ_r;

  // code storage, no reset needed since occupancy gates every read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // occupied flags, cleared at reset so every slot starts empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      rd_occ_r <= 1'b0;
    end else begin
      if (wr_en) begin
        occ_r[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        occ_r[clr_addr] <= 1'b0;
      end
      if (rd_en) begin
        rd_occ_r <= occ_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_occ  = rd_occ_r;

endmodule

>>> rtl/active_error_set.sv
// Active error set: holds up to SLOT_COUNT nonzero error codes.
// Input channel: in_valid/in_stall with in_cmd (add, remove, view first,
// view next) and in_code. Result channel: out_valid/out_stall with
// out_shown, out_shown_code and out_add_dropped; every request gives one
// result.
// Each request is handled by a sequencer that walks the slot memory one
// slot per cycle through a single read port and one shared compare.
// Add and remove walk all SLOT_COUNT slots; a view walks from its start
// slot to the end. A request that walks at least one slot goes from
// accept through the scan state, which issues the reads and compares
// the registered read data, to the finish state, which loads the
// result register; a view next that starts past the last slot passes
// the scan state with no read; an add or remove of code zero skips it.
// One request is in work at a time; in_stall is high while it runs.
// A new request can be accepted while the previous result waits in the
// output register; if the receiver stalls, the finished request holds
// in its last step until the output register is free.
// Reset (rst_n low, synchronous) empties every slot, sets the view
// cursor to the first slot and drops any pending result.
module active_error_set #(
  parameter int SLOT_COUNT = 16,
  parameter int CODE_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_shown,
  output logic [7:0] out_shown_code,
  output logic       out_add_dropped
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           op_r;
  logic [CODE_BITS-1:0] code_r;
  logic                 skip_r;
  logic [CNT_W-1:0]     iss_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 found_r;
  logic [IDX_W-1:0]     found_idx_r;
  logic [CODE_BITS-1:0] found_code_r;
  logic                 have_empty_r;
  logic [IDX_W-1:0]     empty_idx_r;
  logic [CNT_W-1:0]     cursor_r;
  logic                 out_valid_r;
  logic                 out_shown_r;
  logic [7:0]           out_shown_code_r;
  logic                 out_add_dropped_r;

  logic [CODE_BITS-1:0] code_in;
  logic                 in_take;
  logic                 in_skip;
  logic                 issuing;
  logic                 is_view;
  logic [CODE_BITS-1:0] rd_data;
  logic                 rd_occ;
  logic                 hit;
  logic                 fin_go;
  logic                 wr_en;
  logic                 clr_en;

  // request intake
  assign code_in  = CODE_BITS'(in_code);
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign in_skip  = ((in_cmd == ase_pkg::CMD_ADD) || (in_cmd == ase_pkg::CMD_REMOVE))
                    && (code_in == '0);

  // walk control and shared compare
  assign issuing = (state_r == ST_SCAN) && (iss_r < CNT_W'(SLOT_COUNT));
  assign is_view = (op_r == ase_pkg::CMD_VIEW_FIRST) || (op_r == ase_pkg::CMD_VIEW_NEXT);
  assign hit     = rd_vld_r && rd_occ && (is_view || (rd_data == code_r));
  assign fin_go  = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  // slot updates at the end of a request
  assign wr_en  = fin_go && (op_r == ase_pkg::CMD_ADD) && !skip_r && !found_r
                  && have_empty_r;
  assign clr_en = fin_go && (op_r == ase_pkg::CMD_REMOVE) && !skip_r && found_r;

  ase_slot_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .CODE_BITS  (CODE_BITS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (issuing),
    .rd_addr  (iss_r[IDX_W-1:0]),
    .rd_data  (rd_data),
    .rd_occ   (rd_occ),
    .wr_en    (wr_en),
    .wr_addr  (empty_idx_r),
    .wr_data  (code_r),
    .clr_en   (clr_en),
    .clr_addr (found_idx_r)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = in_skip ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issuing && !rd_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issuing;
      if (fin_go && is_view) begin
        cursor_r <= found_r ? (CNT_W'(found_idx_r) + CNT_W'(1)) : CNT_W'(SLOT_COUNT);
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and walk payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r         <= in_cmd;
      code_r       <= code_in;
      skip_r       <= in_skip;
      found_r      <= 1'b0;
      have_empty_r <= 1'b0;
      iss_r        <= (in_cmd == ase_pkg::CMD_VIEW_NEXT) ? cursor_r : '0;
    end else begin
      if (issuing) begin
        iss_r <= iss_r + CNT_W'(1);
      end
      // first hit wins
      if (hit && !found_r) begin
        found_r      <= 1'b1;
        found_idx_r  <= rd_idx_r;
        found_code_r <= rd_data;
      end
      // last empty slot in walk order is the highest-numbered one
      if (rd_vld_r && !rd_occ) begin
        have_empty_r <= 1'b1;
        empty_idx_r  <= rd_idx_r;
      end
    end
    rd_idx_r <= iss_r[IDX_W-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_shown_r       <= is_view && found_r;
      out_shown_code_r  <= (is_view && found_r) ? ase_pkg::SHOWN_BITS'(found_code_r) : '0;
      out_add_dropped_r <= (op_r == ase_pkg::CMD_ADD) && !skip_r && !found_r
                           && !have_empty_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_shown       = out_shown_r;
  assign out_shown_code  = out_shown_code_r;
  assign out_add_dropped = out_add_dropped_r;

endmodule

>>> bench/tb_active_error_set.sv
// self-checking testbench for the active error set
module tb_active_error_set;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT     = 16;
  localparam int CODE_BITS      = 8;
  localparam int RANDOM_ITEMS   = 850;
  localparam int POOL_SIZE      = 20;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int DIRECTED_COUNT = 27;

  // one result as the block reports it
  typedef struct packed {
    logic       shown;
    logic [7:0] shown_code;
    logic       dropped;
  } result_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] code;
    logic       typed;
    logic       shown;
    logic [7:0] shown_code;
    logic       dropped;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // empty set: both views find nothing, code zero is ignored
    '{ase_pkg::CMD_VIEW_FIRST, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_VIEW_NEXT,  8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_REMOVE,     8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    // fill all sixteen slots
    '{ase_pkg::CMD_ADD,        8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h01, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h7F, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'hAA, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h55, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h10, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h20, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h30, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h40, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h0F, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'hF0, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h33, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'hCC, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h11, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'hEE, 1'b1, 1'b0, 8'h00, 1'b0},
    // duplicate add, then a new code on a full set
    '{ase_pkg::CMD_ADD,        8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h99, 1'b1, 1'b0, 8'h00, 1'b1},
    // remove of an absent code
    '{ase_pkg::CMD_REMOVE,     8'h99, 1'b1, 1'b0, 8'h00, 1'b0},
    // walk from the first slot, then free a slot and reuse it
    '{ase_pkg::CMD_VIEW_FIRST, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_VIEW_NEXT,  8'hA5, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_REMOVE,     8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ase_pkg::CMD_ADD,        8'h99, 1'b0, 1'b0, 8'h00, 1'b0}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_cmd;
  logic [7:0] in_code;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_shown;
  logic [7:0] out_shown_code;
  logic       out_add_dropped;

  // model of the slot store and the view cursor
  logic [7:0]  slot_codes [SLOT_COUNT];
  int unsigned view_pos;

  result_t     expected_results [$];
  logic [7:0]  code_pool [POOL_SIZE];

  int mismatch_count  = 0;
  int result_count    = 0;
  int request_count   = 0;
  int random_count    = 0;
  int drop_count      = 0;
  int view_hit_count  = 0;
  int view_miss_count = 0;
  int burst_left      = 0;
  int cycle_count     = 0;

  logic [7:0] stall_tick = '0;
  logic [1:0] stall_mode = '0;
  result_t    oldest_want;

  active_error_set #(
    .SLOT_COUNT(SLOT_COUNT),
    .CODE_BITS (CODE_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_code        (in_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_shown      (out_shown),
    .out_shown_code (out_shown_code),
    .out_add_dropped(out_add_dropped)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // apply one request to the model and return its result
  function automatic result_t apply_request(input logic [1:0] cmd, input logic [7:0] code);
    result_t r;
    logic [7:0] key;
    bit present;
    bit have_empty;
    bit done;
    int empty_idx;
    r = '0;
    key = code & 8'((1 << CODE_BITS) - 1);
    present = 1'b0;
    have_empty = 1'b0;
    done = 1'b0;
    empty_idx = 0;
    case (cmd)
      ase_pkg::CMD_ADD: begin
        if (key != 0) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_codes[i] == key) present = 1'b1;
            if (slot_codes[i] == 0) begin
              empty_idx = i;
              have_empty = 1'b1;
            end
          end
          if (!present) begin
            if (have_empty) slot_codes[empty_idx] = key;
            else r.dropped = 1'b1;
          end
        end
      end
      ase_pkg::CMD_REMOVE: begin
        if (key != 0) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!done && slot_codes[i] == key) begin
              slot_codes[i] = '0;
              done = 1'b1;
            end
          end
        end
      end
      default: begin
        if (cmd == ase_pkg::CMD_VIEW_FIRST) view_pos = 0;
        if (view_pos > SLOT_COUNT) view_pos = SLOT_COUNT;
        while (!done && view_pos < SLOT_COUNT) begin
          if (slot_codes[view_pos] != 0) begin
            r.shown = 1'b1;
            r.shown_code = slot_codes[view_pos];
            done = 1'b1;
          end
          view_pos++;
        end
      end
    endcase
    return r;
  endfunction

  // code for an add or a stray remove: mostly a small pool so codes repeat
  function automatic logic [7:0] pick_code();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 8'h00;
    if (roll < 75) return code_pool[$urandom_range(0, POOL_SIZE - 1)];
    return 8'($urandom_range(1, 255));
  endfunction

  // code that is currently held, so removes mostly hit
  function automatic logic [7:0] pick_present_code();
    int live [$];
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_codes[i] != 0) live.push_back(i);
    end
    if (live.size() == 0) return pick_code();
    return slot_codes[live[$urandom_range(0, live.size() - 1)]];
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch at result %0d: %s got %0h expected %0h",
             result_count, field, got, want);
    mismatch_count++;
  endtask

  // hold a request until accepted, then queue what it should produce
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] code,
                              input logic typed, input result_t typed_want);
    result_t predicted;
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_code  <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(cmd, code);
    if ((cmd == ase_pkg::CMD_VIEW_FIRST || cmd == ase_pkg::CMD_VIEW_NEXT) && !predicted.shown)
      view_miss_count++;
    expected_results.push_back(typed ? typed_want : predicted);
    request_count++;
    @(negedge clk);
  endtask

  // sender goes quiet until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // send in bursts of random length with random gaps between them
  task automatic send_paced(input logic [1:0] cmd, input logic [7:0] code,
                            input logic typed, input result_t typed_want);
    send_request(cmd, code, typed, typed_want);
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 29) == 0) begin
        wait_drained();
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 16);
    end
  endtask

  // random request; ignored ones (code zero on add or remove) are not counted
  task automatic random_request(input logic [1:0] cmd, input logic [7:0] code);
    send_paced(cmd, code, 1'b0, '0);
    if (!((cmd == ase_pkg::CMD_ADD || cmd == ase_pkg::CMD_REMOVE) && code == 0))
      random_count++;
  endtask

  // receiver stall pattern, picking a new mode each time the low six bits of stall_tick are zero
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick[5:0] == 0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 2) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick[2:0] < 3'd3);
    endcase
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, shown_code",
                        int'(out_shown_code), 0);
      end else begin
        oldest_want = expected_results.pop_front();
        if (out_shown !== oldest_want.shown)
          report_mismatch("shown", int'(out_shown), int'(oldest_want.shown));
        if (out_shown_code !== oldest_want.shown_code)
          report_mismatch("shown_code", int'(out_shown_code),
                          int'(oldest_want.shown_code));
        if (out_add_dropped !== oldest_want.dropped)
          report_mismatch("add_dropped", int'(out_add_dropped),
                          int'(oldest_want.dropped));
      end
      if (out_shown === 1'b1) view_hit_count++;
      if (out_add_dropped === 1'b1) drop_count++;
      result_count++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("tb_active_error_set failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    stim_row_t row;
    result_t   row_want;
    bit        fresh;
    int        kind;
    int        n;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_cmd   = ase_pkg::CMD_ADD;
    in_code  = 8'h00;
    for (int i = 0; i < SLOT_COUNT; i++) slot_codes[i] = '0;
    view_pos = 0;
    burst_left = $urandom_range(1, 16);

    // distinct nonzero codes for the random pool
    for (int i = 0; i < POOL_SIZE; i++) begin
      fresh = 1'b0;
      while (!fresh) begin
        code_pool[i] = 8'($urandom_range(1, 255));
        fresh = 1'b1;
        for (int j = 0; j < i; j++) begin
          if (code_pool[j] == code_pool[i]) fresh = 1'b0;
        end
      end
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int k = 0; k < DIRECTED_COUNT; k++) begin
      row = DIRECTED_ROWS[k];
      row_want.shown      = row.shown;
      row_want.shown_code = row.shown_code;
      row_want.dropped    = row.dropped;
      send_paced(row.cmd, row.code, row.typed, row_want);
    end
    wait_drained();

    // random sequences: fill runs, drain runs, view walks and noise
    while (random_count < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        n = $urandom_range(4, 20);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0)
            random_request(ase_pkg::CMD_REMOVE, pick_present_code());
          else random_request(ase_pkg::CMD_ADD, pick_code());
        end
      end else if (kind < 65) begin
        n = $urandom_range(3, 16);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) random_request(ase_pkg::CMD_REMOVE, pick_code());
          else random_request(ase_pkg::CMD_REMOVE, pick_present_code());
        end
      end else if (kind < 90) begin
        random_request(ase_pkg::CMD_VIEW_FIRST, 8'($urandom_range(0, 255)));
        n = $urandom_range(0, SLOT_COUNT + 2);
        repeat (n) random_request(ase_pkg::CMD_VIEW_NEXT, 8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) random_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end

    // drain and let the block settle
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SLOT_COUNT + 8) @(posedge clk);

    $display("covered %0d requests, %0d results; %0d adds refused on a full set",
             request_count, result_count, drop_count);
    $display("views: %0d returned a code, %0d ran off the last slot",
             view_hit_count, view_miss_count);
    if (mismatch_count == 0) begin
      $display("tb_active_error_set passed");
    end else begin
      $display("tb_active_error_set failed");
    end
    $finish;
  end

endmodule
